// ===== sv/soft_dtw_score_table_defines.svh =====
// Assertion helpers for the soft DTW score table.
`ifndef SOFT_DTW_SCORE_TABLE_DEFINES_SVH
`define SOFT_DTW_SCORE_TABLE_DEFINES_SVH

// Clocked assertion, held off while in reset.
`define SDTW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication from one cycle into the next.
`define SDTW_ASSERT_NEXT(label, cond, prop, msg) \
	`SDTW_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ===== sv/sdtw_pkg.sv =====
package sdtw_pkg;

	localparam int MAX_QUERY_FRAMES  = 1024;
	localparam int QIDX_W            = $clog2(MAX_QUERY_FRAMES);
	localparam int LEN_W             = 11;
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int LOG2_E            = $clog2(LOG_TABLE_ENTRIES);
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;

	localparam logic signed [31:0] INF_SCORE = 32'sh7FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUERY_LENGTH   = 3'd0,
		CFG_BAND_HALF      = 3'd1,
		CFG_BAND_ENABLE    = 3'd2,
		CFG_FREE_START     = 3'd3,
		CFG_SHARPNESS      = 3'd4,
		CFG_INV_SHARPNESS  = 3'd5
	} cfg_reg_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_MULT = 6'b000100,
		S_EXP  = 6'b001000,
		S_LOG  = 6'b010000,
		S_FIN  = 6'b100000
	} sdtw_state_t;

	typedef logic [31:0] exp_tab_t [LOG_TABLE_ENTRIES];
	typedef logic [31:0] log_tab_t [LOG_TABLE_ENTRIES+1];

	// shift and subtract quotient, used only while building the tables
	function automatic longint unsigned div_u64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-k/(2E)) by series, then squared five times
	function automatic exp_tab_t build_exp();
		exp_tab_t          tab;
		longint unsigned   t;
		longint unsigned   v;
		longint            sum;
		longint unsigned   e;
		e = longint'(LOG_TABLE_ENTRIES);
		for (int k = 0; k < LOG_TABLE_ENTRIES; k++) begin
			t   = 64'd1 << 30;
			sum = longint'(t);
			for (int n = 1; n <= 24; n++) begin
				t = div_u64(t * longint'(k), 2 * e * longint'(n));
				if ((n & 1) == 1) sum = sum - longint'(t);
				else              sum = sum + longint'(t);
			end
			v = longint'(sum);
			for (int n = 0; n < 5; n++)
				v = (v * v + (64'd1 << 29)) >> 30;
			tab[k] = 32'((v + 64'd8192) >> 14);
		end
		return tab;
	endfunction

	// ln(1+2k/E) = 2 atanh(k/(E+k))
	function automatic log_tab_t build_log();
		log_tab_t          tab;
		longint unsigned   w;
		longint unsigned   w2;
		longint unsigned   p;
		longint unsigned   sum;
		longint unsigned   e;
		e = longint'(LOG_TABLE_ENTRIES);
		for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
			w   = div_u64(longint'(k) << 30, e + longint'(k));
			w2  = (w * w) >> 30;
			p   = w;
			sum = 0;
			for (int n = 0; n < 40; n++) begin
				if (p != 0) begin
					sum = sum + div_u64(p, longint'(2 * n + 1));
					p   = (p * w2) >> 30;
				end
			end
			tab[k] = 32'((2 * sum + 64'd8192) >> 14);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TABLE = build_exp();
	localparam log_tab_t LOG_TABLE = build_log();

endpackage

// ===== sv/sdtw_if.sv =====
interface sdtw_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cell_cost;
	logic               end_of_sequence;
	modport source (output valid, cell_cost, end_of_sequence, input ready);
	modport sink (input valid, cell_cost, end_of_sequence, output ready);
endinterface

interface sdtw_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cell_score;
	logic               is_final_score;
	modport source (output valid, cell_score, is_final_score, input ready);
	modport sink (input valid, cell_score, is_final_score, output ready);
endinterface

// ===== sv/sdtw_ram.sv =====
module sdtw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/soft_dtw_score_table.sv =====
// Soft DTW forward score table: one cell score per cost beat.
// An accepted cost beat walks READ, MULT, EXP, LOG and FIN: the column memory
// read, the sharpness multiply, the exp and log table steps and the final add,
// one per cycle, FIN holding while the score beat is stalled; a new beat is
// taken only in IDLE. Reset returns the settings and the recursion state
// to their reset values; the column memory is not cleared and is written before use.
`include "soft_dtw_score_table_defines.svh"

module soft_dtw_score_table
	import sdtw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sdtw_in_if.sink               in_ch,
	sdtw_out_if.source            out_ch
);
	localparam int PROD_W = 48;

	sdtw_state_t state_q;

	logic [LEN_W-1:0]  query_length_q;
	logic [9:0]        band_half_q;
	logic              band_en_q;
	logic              free_start_q;
	logic [15:0]       sharp_q;
	logic [15:0]       inv_sharp_q;

	logic [QIDX_W-1:0] qidx_q;
	logic [31:0]       col_q;
	logic signed [31:0] above_q;
	logic signed [31:0] diag_q;

	logic signed [31:0] cost_s1;
	logic               eos_s1;
	logic [QIDX_W-1:0]  q_s1;
	logic [31:0]        c_s1;

	logic signed [31:0] left_s2;
	logic signed [31:0] m_s2;
	logic [31:0]        d_s2   [3];
	logic [2:0]         fin_s2;
	logic [PROD_W-1:0]  prod_s3 [3];
	logic [LOG2_E:0]    li_s4;
	logic signed [33:0] soft_s5;

	logic               out_valid_q;
	logic signed [31:0] out_score_q;
	logic               out_final_q;

	logic [31:0]        ram_rdata;
	logic               ram_we;
	logic signed [31:0] score;

	// column memory
	sdtw_ram #(.WIDTH(32), .DEPTH(MAX_QUERY_FRAMES)) u_col_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_s1),
		.wdata (score),
		.raddr (qidx_q),
		.rdata (ram_rdata)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.cell_score = out_score_q;
	assign out_ch.is_final_score = out_final_q;

	logic fin_go;
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);
	assign ram_we = fin_go;

	// min of three neighbours
	logic signed [31:0] nb [3];
	logic signed [31:0] m_min;
	always_comb begin
		nb[0] = signed'(ram_rdata);
		nb[1] = above_q;
		nb[2] = diag_q;
		m_min = nb[0];
		if (nb[1] < m_min) m_min = nb[1];
		if (nb[2] < m_min) m_min = nb[2];
	end

	// exp terms and log index
	logic [19:0]       s_sum;
	logic [19:0]       s_diff;
	logic [19:0]       li_raw;
	logic [LOG2_E:0]   li_next;
	always_comb begin
		s_sum = '0;
		for (int i = 0; i < 3; i++) begin
			if (fin_s2[i] && prod_s3[i][PROD_W-1:32] == '0)
				s_sum = s_sum + 20'(EXP_TABLE[prod_s3[i][31:32-LOG2_E]]);
		end
		s_diff = s_sum - 20'd65536;
		li_raw = s_diff >> (17 - LOG2_E);
		if (s_sum < 20'd65536 || li_raw > 20'(LOG_TABLE_ENTRIES))
			li_next = (LOG2_E+1)'(LOG_TABLE_ENTRIES);
		else
			li_next = li_raw[LOG2_E:0];
	end

	logic [47:0] p2;
	assign p2 = 48'(inv_sharp_q) * 48'(LOG_TABLE[li_s4]);

	// final score
	logic               interior;
	logic [31:0]        gap;
	logic               band_out;
	logic signed [33:0] base;
	logic               base_inf;
	logic signed [34:0] sum35;
	always_comb begin
		interior = (c_s1 != '0) && (q_s1 != '0);
		gap = (32'(q_s1) > c_s1) ? 32'(q_s1) - c_s1 : c_s1 - 32'(q_s1);
		band_out = band_en_q && (gap > 32'(band_half_q));
		base_inf = 1'b0;
		if (c_s1 == '0)
			base = (q_s1 == '0) ? 34'sd0 : 34'(above_q);
		else if (q_s1 == '0)
			base = free_start_q ? 34'sd0 : 34'(left_s2);
		else begin
			base = soft_s5;
			base_inf = (m_s2 == INF_SCORE);
		end
		sum35 = 35'(base) + 35'(cost_s1);
		if (interior && band_out)
			score = INF_SCORE;
		else if (base_inf || base >= 34'(INF_SCORE) || cost_s1 == INF_SCORE)
			score = INF_SCORE;
		else if (sum35 >= 35'(INF_SCORE))
			score = INF_SCORE;
		else if (sum35 < -35'sh8000_0000)
			score = 32'sh8000_0000;
		else
			score = sum35[31:0];
	end

	logic [LEN_W-1:0] len_eff;
	always_comb begin
		if (query_length_q == '0)
			len_eff = LEN_W'(1);
		else if (query_length_q > LEN_W'(MAX_QUERY_FRAMES))
			len_eff = LEN_W'(MAX_QUERY_FRAMES);
		else
			len_eff = query_length_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= LEN_W'(1024);
			band_half_q    <= 10'd3;
			band_en_q      <= 1'b0;
			free_start_q   <= 1'b0;
			sharp_q        <= 16'd8192;
			inv_sharp_q    <= 16'd2048;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_QUERY_LENGTH:  query_length_q <= cfg_wdata[LEN_W-1:0];
				CFG_BAND_HALF:     band_half_q    <= cfg_wdata[9:0];
				CFG_BAND_ENABLE:   band_en_q      <= cfg_wdata[0];
				CFG_FREE_START:    free_start_q   <= cfg_wdata[0];
				CFG_SHARPNESS:     sharp_q        <= cfg_wdata;
				CFG_INV_SHARPNESS: inv_sharp_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qidx_q      <= '0;
			col_q       <= '0;
			above_q     <= INF_SCORE;
			diag_q      <= INF_SCORE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) state_q <= S_READ;
				end
				S_READ: state_q <= S_MULT;
				S_MULT: state_q <= S_EXP;
				S_EXP:  state_q <= S_LOG;
				S_LOG:  state_q <= S_FIN;
				S_FIN: begin
					// hold until the output register frees
					if (fin_go) begin
						state_q <= S_IDLE;
						if (eos_s1) begin
							qidx_q  <= '0;
							col_q   <= '0;
							above_q <= INF_SCORE;
							diag_q  <= INF_SCORE;
						end else begin
							if (c_s1 != '0) diag_q <= left_s2;
							if (LEN_W'(q_s1) + LEN_W'(1) >= len_eff) begin
								qidx_q  <= '0;
								if (col_q != '1) col_q <= col_q + 32'd1;
								above_q <= INF_SCORE;
							end else begin
								qidx_q  <= q_s1 + QIDX_W'(1);
								above_q <= score;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			cost_s1 <= in_ch.cell_cost;
			eos_s1  <= in_ch.end_of_sequence;
			q_s1    <= qidx_q;
			c_s1    <= col_q;
		end
		if (state_q == S_READ) begin
			left_s2 <= signed'(ram_rdata);
			m_s2    <= m_min;
			for (int i = 0; i < 3; i++) begin
				fin_s2[i] <= (nb[i] != INF_SCORE);
				d_s2[i]   <= 32'(nb[i] - m_min);
			end
		end
		if (state_q == S_MULT) begin
			for (int i = 0; i < 3; i++)
				prod_s3[i] <= PROD_W'(d_s2[i]) * PROD_W'(sharp_q);
		end
		if (state_q == S_EXP) li_s4 <= li_next;
		if (state_q == S_LOG) soft_s5 <= 34'(m_s2) - 34'(p2 >> 12);
		if (fin_go) begin
			out_score_q <= score;
			out_final_q <= eos_s1;
		end
	end

	`SDTW_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
	`SDTW_ASSERT_NEXT(a_accept_moves, in_ch.valid && in_ch.ready, state_q == S_READ,
		"accepted beat did not start a cell")
	`SDTW_ASSERT_NEXT(a_out_from_fin, !out_valid_q, !out_valid_q || $past(state_q == S_FIN),
		"score beat raised outside the final step")
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sdtw_pkg::*;

	localparam longint SCORE_INF = 64'sh7FFF_FFFF;
	localparam longint SCORE_MIN = -64'sh8000_0000;
	localparam int     CYCLE_LIMIT = 2_000_000;

	typedef enum bit {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		cfg_reg_t           reg_id;
		logic [15:0]        value;
		logic signed [31:0] cost;
		logic               eos;
		bit                 typed;
		logic signed [31:0] want;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] score;
		logic               last;
	} score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	sdtw_in_if  in_ch();
	sdtw_out_if out_ch();

	soft_dtw_score_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the block: tables, settings and recursion state.
	longint unsigned exp_lut [LOG_TABLE_ENTRIES];
	longint unsigned ln_lut [LOG_TABLE_ENTRIES+1];
	int unsigned m_len, m_band, m_band_on, m_free, m_sharp, m_inv;
	longint      col_mem [MAX_QUERY_FRAMES];
	int unsigned row_at, col_at;
	longint      above, diag;

	score_t    score_q[$];
	stim_row_t rows[$];
	int        fails = 0;
	int        cycles = 0;
	bit        quiet = 1'b0;
	bit        busy = 1'b0;
	int        stall_left = 0;

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		fails++;
		$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void fill_luts();
		longint unsigned e, t, v, w, w2, p, acc;
		longint          s;
		e = LOG_TABLE_ENTRIES;
		for (int k = 0; k < LOG_TABLE_ENTRIES; k++) begin
			t = 64'd1 << 30;
			s = longint'(t);
			for (int n = 1; n <= 24; n++) begin
				t = t * k / (2 * e * n);
				s = (n & 1) ? s - longint'(t) : s + longint'(t);
			end
			v = s;
			repeat (5) v = (v * v + (64'd1 << 29)) >> 30;
			exp_lut[k] = (v + 8192) >> 14;
		end
		for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
			w = (longint'(k) << 30) / (e + k);
			w2 = (w * w) >> 30;
			p = w;
			acc = 0;
			for (int n = 0; n < 40 && p != 0; n++) begin
				acc += p / (2 * n + 1);
				p = (p * w2) >> 30;
			end
			ln_lut[k] = (2 * acc + 8192) >> 14;
		end
	endfunction

	function automatic longint sat_add(input longint base, input longint cost);
		longint s;
		if (base >= SCORE_INF || cost >= SCORE_INF) return SCORE_INF;
		s = base + cost;
		if (s >= SCORE_INF) return SCORE_INF;
		if (s < SCORE_MIN) return SCORE_MIN;
		return s;
	endfunction

	function automatic longint smooth_min(input longint a, input longint b, input longint c);
		longint          nb [3];
		longint          lo;
		longint unsigned sum, d, t, idx, li;
		nb[0] = a;
		nb[1] = b;
		nb[2] = c;
		lo = SCORE_INF;
		sum = 0;
		foreach (nb[i]) if (nb[i] < lo) lo = nb[i];
		if (lo >= SCORE_INF) return SCORE_INF;
		foreach (nb[i]) begin
			if (nb[i] < SCORE_INF) begin
				d = nb[i] - lo;
				t = (d * m_sharp) >> 12;
				idx = (t * LOG_TABLE_ENTRIES) >> 20;
				if (idx < LOG_TABLE_ENTRIES) sum += exp_lut[idx];
			end
		end
		li = ((sum - 65536) * LOG_TABLE_ENTRIES) >> 17;
		if (li > LOG_TABLE_ENTRIES) li = LOG_TABLE_ENTRIES;
		return lo - longint'((longint'(m_inv) * ln_lut[li]) >> 12);
	endfunction

	function automatic void restart_table();
		row_at = 0;
		col_at = 0;
		above = SCORE_INF;
		diag = SCORE_INF;
	endfunction

	function automatic int unsigned eff_len();
		if (m_len == 0) return 1;
		if (m_len > MAX_QUERY_FRAMES) return MAX_QUERY_FRAMES;
		return m_len;
	endfunction

	function automatic logic signed [31:0] next_score(input logic signed [31:0] cost,
			input logic eos);
		int unsigned q, gap;
		longint      sc, left, cv;
		q = (row_at >= MAX_QUERY_FRAMES) ? MAX_QUERY_FRAMES - 1 : row_at;
		cv = cost;
		if (col_at == 0) begin
			sc = (q == 0) ? sat_add(0, cv) : sat_add(above, cv);
		end else if (q == 0) begin
			diag = col_mem[0];
			sc = m_free ? sat_add(0, cv) : sat_add(col_mem[0], cv);
		end else begin
			left = col_mem[q];
			gap = (q > col_at) ? q - col_at : col_at - q;
			if (m_band_on && gap > m_band) sc = SCORE_INF;
			else sc = sat_add(smooth_min(left, above, diag), cv);
			diag = left;
		end
		col_mem[q] = sc;
		above = sc;
		if (eos) begin
			restart_table();
		end else if (q + 1 >= eff_len()) begin
			row_at = 0;
			if (col_at != 32'hFFFF_FFFF) col_at++;
			above = SCORE_INF;
		end else begin
			row_at = q + 1;
		end
		return sc[31:0];
	endfunction

	function automatic void apply_reg(input cfg_reg_t r, input logic [15:0] v);
		case (r)
			CFG_QUERY_LENGTH:  m_len = v[10:0];
			CFG_BAND_HALF:     m_band = v[9:0];
			CFG_BAND_ENABLE:   m_band_on = v[0];
			CFG_FREE_START:    m_free = v[0];
			CFG_SHARPNESS:     m_sharp = v;
			CFG_INV_SHARPNESS: m_inv = v;
			default: ;
		endcase
	endfunction

	// Wait until every score is back; the block gives one per cost beat.
	task automatic drain();
		if (busy) begin
			in_ch.valid <= 1'b0;
			while (score_q.size() != 0) @(posedge clk);
			repeat (10) @(posedge clk);
			busy = 1'b0;
		end
	endtask

	// Leaves cfg_we high; the next cost beat lowers it.
	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		apply_reg(r, v);
	endtask

	task automatic send_cell(input logic signed [31:0] cost, input logic eos, input bit typed,
			input logic signed [31:0] want);
		int     gap;
		score_t e;
		cfg_we <= 1'b0;
		gap = (!quiet && $urandom_range(0, 9) < 3) ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cell_cost <= cost;
		in_ch.end_of_sequence <= eos;
		busy = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		e.score = next_score(cost, eos);
		e.last = eos;
		if (typed) e.score = want;
		score_q.push_back(e);
	endtask

	function automatic logic signed [31:0] draw_cost();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $signed($urandom_range(0, 524287)) - 262144;
		if (r < 75) return $urandom;
		if (r < 85) return INF_SCORE;
		if (r < 90) return 32'sh8000_0000;
		return $signed($urandom_range(0, 33554431)) - 16777216;
	endfunction

	// One table pass: cells column by column, end mark on the last one.
	task automatic run_sequence(input int cells);
		for (int i = 0; i < cells; i++)
			send_cell(draw_cost(), i == cells - 1, 1'b0, '0);
	endtask

	function automatic void add_cfg(input cfg_reg_t r, input logic [15:0] v);
		stim_row_t s;
		s = '{ROW_CFG, r, v, '0, 1'b0, 1'b0, '0};
		rows.push_back(s);
	endfunction

	function automatic void add_beat(input logic signed [31:0] cost, input logic eos,
			input bit typed, input logic signed [31:0] want);
		stim_row_t s;
		s = '{ROW_BEAT, CFG_QUERY_LENGTH, '0, cost, eos, typed, want};
		rows.push_back(s);
	endfunction

	always @(posedge clk) begin
		score_t e;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (score_q.size() == 0) begin
					flag_mismatch("unexpected beat", out_ch.cell_score, 0);
				end else begin
					e = score_q.pop_front();
					if (out_ch.cell_score !== e.score)
						flag_mismatch("cell_score", out_ch.cell_score, e.score);
					if (out_ch.is_final_score !== e.last)
						flag_mismatch("is_final_score", out_ch.is_final_score, e.last);
				end
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 9) < 2) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		int          beats;
		int unsigned n;
		in_ch.valid = 1'b0;
		in_ch.cell_cost = '0;
		in_ch.end_of_sequence = 1'b0;
		out_ch.ready = 1'b0;
		fill_luts();
		foreach (col_mem[i]) col_mem[i] = 0;
		m_len = 1024;
		m_band = 3;
		m_band_on = 0;
		m_free = 0;
		m_sharp = 8192;
		m_inv = 2048;
		restart_table();

		// Directed rows: extremes, saturation, free start, band, length edges.
		add_beat(32'sh8000_0000, 1'b0, 1'b1, 32'sh8000_0000);
		add_beat(INF_SCORE, 1'b1, 1'b1, INF_SCORE);
		add_cfg(CFG_QUERY_LENGTH, 16'd2);
		add_cfg(CFG_FREE_START, 16'd1);
		add_beat(32'sh0001_0000, 1'b0, 1'b1, 32'sh0001_0000);
		add_beat(32'sh7FFF_FFFE, 1'b0, 1'b1, INF_SCORE);
		add_beat(32'sh0005_0000, 1'b0, 1'b1, 32'sh0005_0000);
		add_beat(32'sh0000_0000, 1'b0, 1'b0, '0);
		add_beat(-32'sd1, 1'b1, 1'b0, '0);
		add_cfg(CFG_FREE_START, 16'd0);
		add_cfg(CFG_QUERY_LENGTH, 16'd0);
		add_beat(32'sh0002_0000, 1'b0, 1'b1, 32'sh0002_0000);
		add_beat(32'sh0003_0000, 1'b0, 1'b1, 32'sh0005_0000);
		add_beat(32'sh8000_0000, 1'b1, 1'b1, 32'sh8005_0000);
		add_cfg(CFG_QUERY_LENGTH, 16'd3);
		add_cfg(CFG_BAND_ENABLE, 16'd1);
		add_cfg(CFG_BAND_HALF, 16'd0);
		add_cfg(CFG_SHARPNESS, 16'd65535);
		add_cfg(CFG_INV_SHARPNESS, 16'd65535);
		for (int i = 0; i < 6; i++) add_beat(32'sh0000_8000 * i, i == 5, 1'b0, '0);
		add_cfg(CFG_BAND_HALF, 16'd1023);
		add_cfg(CFG_SHARPNESS, 16'd1);
		add_cfg(CFG_INV_SHARPNESS, 16'd1);
		for (int i = 0; i < 6; i++) add_beat(32'sh0001_0000 - 32'sh0000_4000 * i, i == 5,
			1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) write_reg(rows[i].reg_id, rows[i].value);
			else send_cell(rows[i].cost, rows[i].eos, rows[i].typed, rows[i].want);
		end

		// Longest length setting: a short first column under the field's top value.
		write_reg(CFG_QUERY_LENGTH, 16'd2047);
		write_reg(CFG_BAND_ENABLE, 16'd0);
		write_reg(CFG_SHARPNESS, 16'd8192);
		write_reg(CFG_INV_SHARPNESS, 16'd2048);
		run_sequence(20);

		beats = 0;
		while (beats < 500) begin
			quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(0, 19);
			write_reg(CFG_QUERY_LENGTH, n == 0 ? 16'd0 : n == 1 ? 16'd1 : 16'($urandom_range(2, 8)));
			write_reg(CFG_BAND_HALF, $urandom_range(0, 4) == 0 ? 16'd1023
				: 16'($urandom_range(0, 3)));
			write_reg(CFG_BAND_ENABLE, 16'($urandom_range(0, 1)));
			write_reg(CFG_FREE_START, 16'($urandom_range(0, 1)));
			n = $urandom_range(0, 9);
			write_reg(CFG_SHARPNESS, n == 0 ? 16'd1 : n == 1 ? 16'd65535
				: 16'($urandom_range(1024, 32768)));
			n = $urandom_range(0, 9);
			write_reg(CFG_INV_SHARPNESS, n == 0 ? 16'd1 : n == 1 ? 16'd65535
				: 16'($urandom_range(256, 8192)));
			repeat ($urandom_range(1, 3)) begin
				// Mostly whole columns; now and then an early end mark.
				n = eff_len() * $urandom_range(1, 6);
				if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
				run_sequence(n);
				beats += n;
			end
		end

		quiet = 1'b0;
		in_ch.valid <= 1'b0;
		while (score_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule
